@@ design/av_sync_video_frame_scheduler_top_macros.svh @@
// assertion macros used by the scheduler datapath
// expects clk and rst in the scope of use
`ifndef AV_SYNC_VIDEO_FRAME_SCHEDULER_TOP_MACROS_SVH
`define AV_SYNC_VIDEO_FRAME_SCHEDULER_TOP_MACROS_SVH
// same-cycle implication
`define AVS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define AVS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ design/avs_pkg.sv @@
// shared constants, codes and control structs of the av sync scheduler
// no dependencies
package avs_pkg;

  localparam int QUEUE_DEPTH_DEF = 3;
  localparam int TIME_WIDTH_DEF  = 48;

  localparam int CALC_W    = 64;
  localparam int DIV_NUM_W = 39;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;
  localparam int PEND_W    = 17;

  // rtp ticks to microseconds: floor(t * 125 / 6) at 48 kHz, floor(t * 100 / 9) at 90 kHz
  localparam logic [31:0]          AUDIO_MAGIC = 32'hAAAA_AAAB;
  localparam int                   AUDIO_SHIFT = 34;
  localparam logic [31:0]          AUDIO_DEN   = 32'd6;
  localparam logic [DIV_NUM_W-1:0] AUDIO_MUL   = DIV_NUM_W'(125);
  localparam logic [31:0]          VIDEO_MAGIC = 32'h38E3_8E39;
  localparam int                   VIDEO_SHIFT = 33;
  localparam logic [31:0]          VIDEO_DEN   = 32'd9;
  localparam logic [DIV_NUM_W-1:0] VIDEO_MUL   = DIV_NUM_W'(100);

  localparam logic [15:0] PREBUF_RST  = 16'd3840;
  localparam logic [15:0] MAXPEND_RST = 16'd11520;
  localparam logic [19:0] EARLY_RST   = 20'd10000;
  localparam logic [19:0] LATE_RST    = 20'd100000;
  localparam logic [23:0] MISSING_RST = 24'd200000;

  localparam logic [1:0] MODE_VIDEO  = 2'd0;
  localparam logic [1:0] MODE_AUDIO  = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_PREBUF  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAXPEND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EARLY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LATE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MISSING = 3'd4;

  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 4'd1;
  localparam logic [OP_W-1:0] OP_VIDEO  = 4'd2;
  localparam logic [OP_W-1:0] OP_AUDIO  = 4'd3;
  localparam logic [OP_W-1:0] OP_WRITE  = 4'd4;
  localparam logic [OP_W-1:0] OP_ABASE  = 4'd5;
  localparam logic [OP_W-1:0] OP_SETUP  = 4'd6;
  localparam logic [OP_W-1:0] OP_VSTART = 4'd7;
  localparam logic [OP_W-1:0] OP_DIFF   = 4'd8;
  localparam logic [OP_W-1:0] OP_DROP   = 4'd9;
  localparam logic [OP_W-1:0] OP_SHOW   = 4'd10;
  localparam logic [OP_W-1:0] OP_OUT    = 4'd11;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       go;
    logic       div_busy;
    logic       q_empty;
    logic       wait_f;
    logic       drop_f;
  } status_t;

endpackage

@@ design/avs_ifs.sv @@
// event and result channel interfaces of the av sync scheduler
// depends on avs_pkg
interface avs_ev_if #(parameter int TIME_WIDTH = avs_pkg::TIME_WIDTH_DEF);
  logic                  valid;
  logic                  ready;
  logic [1:0]            mode;
  logic [31:0]           rtp_timestamp;
  logic [15:0]           frame_handle;
  logic [13:0]           audio_byte_count;
  logic [TIME_WIDTH-1:0] now_us;
  logic [TIME_WIDTH-1:0] audio_played_us;
  logic                  sink_idle;
  logic [15:0]           device_free_bytes;
  logic                  device_ok;
  modport source(output valid, mode, rtp_timestamp, frame_handle, audio_byte_count, now_us,
                 audio_played_us, sink_idle, device_free_bytes, device_ok, input ready);
  modport sink(input valid, mode, rtp_timestamp, frame_handle, audio_byte_count, now_us,
               audio_played_us, sink_idle, device_free_bytes, device_ok, output ready);
endinterface

interface avs_res_if;
  logic        valid;
  logic        ready;
  logic        frame_valid;
  logic [15:0] frame_shown;
  logic [1:0]  frames_dropped;
  logic [15:0] audio_bytes_written;
  logic        audio_started;
  logic        audio_unavailable;
  modport source(output valid, frame_valid, frame_shown, frames_dropped, audio_bytes_written,
                 audio_started, audio_unavailable, input ready);
  modport sink(input valid, frame_valid, frame_shown, frames_dropped, audio_bytes_written,
               audio_started, audio_unavailable, output ready);
endinterface

@@ design/avs_div.sv @@
// rtp tick to microsecond converter: reciprocal multiply, remainder, scale
// depends on avs_pkg
module avs_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [31:0]                    ticks,
  input  logic                           video,
  output logic                           busy,
  output logic [avs_pkg::DIV_NUM_W-1:0]  quot
);
  logic [31:0] tk_r;
  logic        vid_r;
  logic [1:0]  phase;
  logic [63:0] prod;
  logic [31:0] q_r;
  logic [3:0]  r_r;
  logic [31:0] magic, den, q_c, qd_c;
  logic [3:0]  r_c;
  logic [6:0]  frac;
  logic [avs_pkg::DIV_NUM_W-1:0] whole;

  always_comb begin
    magic = vid_r ? avs_pkg::VIDEO_MAGIC : avs_pkg::AUDIO_MAGIC;
    den   = vid_r ? avs_pkg::VIDEO_DEN : avs_pkg::AUDIO_DEN;
    q_c   = vid_r ? 32'(prod >> avs_pkg::VIDEO_SHIFT) : 32'(prod >> avs_pkg::AUDIO_SHIFT);
    qd_c  = q_c * den;
    r_c   = 4'(tk_r - qd_c);
    whole = vid_r ? avs_pkg::DIV_NUM_W'(q_r) * avs_pkg::VIDEO_MUL
                  : avs_pkg::DIV_NUM_W'(q_r) * avs_pkg::AUDIO_MUL;
    frac  = '0;
    // remainder share of the scaled quotient
    if (vid_r) begin
      case (r_r)
        4'd1:    frac = 7'd11;
        4'd2:    frac = 7'd22;
        4'd3:    frac = 7'd33;
        4'd4:    frac = 7'd44;
        4'd5:    frac = 7'd55;
        4'd6:    frac = 7'd66;
        4'd7:    frac = 7'd77;
        4'd8:    frac = 7'd88;
        default: frac = '0;
      endcase
    end else begin
      case (r_r)
        4'd1:    frac = 7'd20;
        4'd2:    frac = 7'd41;
        4'd3:    frac = 7'd62;
        4'd4:    frac = 7'd83;
        4'd5:    frac = 7'd104;
        default: frac = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      phase <= '0;
    end else if (busy) begin
      phase <= phase + 1'b1;
      if (phase == 2'd2) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      tk_r  <= ticks;
      vid_r <= video;
    end else if (busy) begin
      case (phase)
        2'd0: prod <= 64'(tk_r) * 64'(magic);
        2'd1: begin
          q_r <= q_c;
          r_r <= r_c;
        end
        2'd2: quot <= whole + avs_pkg::DIV_NUM_W'(frac);
        default: ;
      endcase
    end
  end
endmodule

@@ design/avs_dp.sv @@
// datapath: config registers, frame queue, audio accounting, clock compare
// depends on avs_pkg, avs_div and the macros header
`include "av_sync_video_frame_scheduler_top_macros.svh"
module avs_dp #(
  parameter int QUEUE_DEPTH = avs_pkg::QUEUE_DEPTH_DEF,
  parameter int TIME_WIDTH  = avs_pkg::TIME_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [avs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [avs_pkg::CFG_DAT_W-1:0]  cfg_data,
  input  logic [1:0]                     mode,
  input  logic [31:0]                    rtp_timestamp,
  input  logic [15:0]                    frame_handle,
  input  logic [13:0]                    audio_byte_count,
  input  logic [TIME_WIDTH-1:0]          now_us,
  input  logic [TIME_WIDTH-1:0]          audio_played_us,
  input  logic                           sink_idle,
  input  logic [15:0]                    device_free_bytes,
  input  logic                           device_ok,
  input  avs_pkg::cmd_t                  cmd,
  output avs_pkg::status_t               status,
  output logic                           frame_valid,
  output logic [15:0]                    frame_shown,
  output logic [1:0]                     frames_dropped,
  output logic [15:0]                    audio_bytes_written,
  output logic                           audio_started,
  output logic                           audio_unavailable
);
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CW    = avs_pkg::CALC_W;

  logic [15:0] prebuf, maxpend;
  logic [19:0] early, late;
  logic [23:0] missing;

  logic [1:0]            mode_r;
  logic [31:0]           ts_r;
  logic [15:0]           handle_r;
  logic [13:0]           bytes_r;
  logic [TIME_WIDTH-1:0] now_r, played_r;
  logic                  idle_r, ok_r;
  logic [15:0]           free_r;

  logic [31:0] q_ts [QUEUE_DEPTH];
  logic [15:0] q_hd [QUEUE_DEPTH];
  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] count;

  logic                  have_vs, have_as, sink_running, audio_disabled, recent;
  logic [31:0]           first_vts, first_ats;
  logic [TIME_WIDTH-1:0] first_varr, first_aarr, last_aarr;
  logic [avs_pkg::PEND_W-1:0] pending;
  logic [CW-1:0] master, offset, diff;

  logic        res_valid;
  logic [15:0] res_shown, res_written;
  logic [1:0]  res_dropped;

  logic [IDX_W:0]   tail_sum, tail;
  logic [IDX_W-1:0] head_inc, wr_idx;
  logic             full;
  logic [avs_pkg::PEND_W:0]   sum;
  logic [avs_pkg::PEND_W-1:0] capped, wr_amt;
  logic [CW-1:0]    since, mag, base;
  logic             recent_c;
  logic [31:0]      delta;
  logic             div_start, div_busy, div_video;
  logic [31:0]      div_ticks;
  logic [avs_pkg::DIV_NUM_W-1:0] quot;

  always_comb begin
    tail_sum = {1'b0, head} + (IDX_W+1)'(count);
    tail     = (tail_sum >= (IDX_W+1)'(QUEUE_DEPTH)) ? tail_sum - (IDX_W+1)'(QUEUE_DEPTH)
                                                       : tail_sum;
    head_inc = (head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
    full     = count == CNT_W'(QUEUE_DEPTH);
    wr_idx   = full ? head : tail[IDX_W-1:0];
    sum      = {1'b0, pending} + (avs_pkg::PEND_W+1)'(bytes_r);
    capped   = (sum > (avs_pkg::PEND_W+1)'(maxpend)) ? avs_pkg::PEND_W'(maxpend)
                                                      : sum[avs_pkg::PEND_W-1:0];
    if (!sink_running || pending == '0) wr_amt = '0;
    else if (avs_pkg::PEND_W'(free_r) < pending) wr_amt = avs_pkg::PEND_W'(free_r);
    else wr_amt = pending;
    since    = CW'(now_r) - CW'(last_aarr);
    recent_c = since[CW-1] || (since < CW'(missing));
    delta    = q_ts[head] - first_vts;
    base     = CW'(quot);
    mag      = '0 - diff;
    div_start = (cmd.op == avs_pkg::OP_ABASE) || (cmd.op == avs_pkg::OP_VSTART);
    div_video = cmd.op != avs_pkg::OP_ABASE;
    div_ticks = div_video ? delta : first_ats;
  end

  avs_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .ticks(div_ticks),
    .video(div_video),
    .busy (div_busy),
    .quot (quot)
  );

  always_comb begin
    status.mode     = mode_r;
    status.go       = (count != '0) && !(have_as && !audio_disabled && !sink_running && recent);
    status.div_busy = div_busy;
    status.q_empty  = count == '0;
    status.wait_f   = !diff[CW-1] && (diff > CW'(early));
    status.drop_f   = diff[CW-1] && (mag > CW'(late));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prebuf  <= avs_pkg::PREBUF_RST;
      maxpend <= avs_pkg::MAXPEND_RST;
      early   <= avs_pkg::EARLY_RST;
      late    <= avs_pkg::LATE_RST;
      missing <= avs_pkg::MISSING_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        avs_pkg::REG_PREBUF:  prebuf  <= cfg_data[15:0];
        avs_pkg::REG_MAXPEND: maxpend <= cfg_data[15:0];
        avs_pkg::REG_EARLY:   early   <= cfg_data[19:0];
        avs_pkg::REG_LATE:    late    <= cfg_data[19:0];
        avs_pkg::REG_MISSING: missing <= cfg_data;
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head           <= '0;
      count          <= '0;
      have_vs        <= 1'b0;
      have_as        <= 1'b0;
      sink_running   <= 1'b0;
      audio_disabled <= 1'b0;
      first_vts      <= '0;
      first_ats      <= '0;
      first_varr     <= '0;
      first_aarr     <= '0;
      last_aarr      <= '0;
      pending        <= '0;
    end else begin
      case (cmd.op)
        avs_pkg::OP_VIDEO: begin
          if (!have_vs) begin
            have_vs    <= 1'b1;
            first_vts  <= ts_r;
            first_varr <= now_r;
          end
          if (full) head <= head_inc;
          else count <= count + 1'b1;
        end
        avs_pkg::OP_AUDIO: begin
          if (!audio_disabled) begin
            if (!have_as) begin
              have_as    <= 1'b1;
              first_ats  <= ts_r;
              first_aarr <= now_r;
            end
            last_aarr <= now_r;
            pending   <= capped;
            if (!sink_running && capped >= avs_pkg::PEND_W'(prebuf)) begin
              if (ok_r) sink_running <= 1'b1;
              else begin
                audio_disabled <= 1'b1;
                pending        <= '0;
              end
            end
          end
        end
        avs_pkg::OP_WRITE: pending <= pending - wr_amt;
        avs_pkg::OP_DROP, avs_pkg::OP_SHOW: begin
          head  <= head_inc;
          count <= count - 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      avs_pkg::OP_LOAD: begin
        mode_r      <= mode;
        ts_r        <= rtp_timestamp;
        handle_r    <= frame_handle;
        bytes_r     <= audio_byte_count;
        now_r       <= now_us;
        played_r    <= audio_played_us;
        idle_r      <= sink_idle;
        free_r      <= device_free_bytes;
        ok_r        <= device_ok;
        res_valid   <= 1'b0;
        res_shown   <= '0;
        res_dropped <= '0;
        res_written <= '0;
      end
      avs_pkg::OP_VIDEO: begin
        q_ts[wr_idx] <= ts_r;
        q_hd[wr_idx] <= handle_r;
        if (full) res_dropped <= 2'd1;
      end
      avs_pkg::OP_WRITE: begin
        res_written <= wr_amt[15:0];
        recent      <= recent_c;
      end
      avs_pkg::OP_SETUP: begin
        if (sink_running && (!idle_r || recent || pending != '0)) begin
          master <= base + CW'(played_r);
          offset <= base + (CW'(first_varr) - CW'(first_aarr));
        end else begin
          master <= CW'(now_r);
          offset <= CW'(first_varr);
        end
      end
      avs_pkg::OP_DIFF: diff <= offset + CW'(quot) - master;
      avs_pkg::OP_DROP: if (res_dropped != 2'd3) res_dropped <= res_dropped + 1'b1;
      avs_pkg::OP_SHOW: begin
        res_valid <= 1'b1;
        res_shown <= q_hd[head];
      end
      avs_pkg::OP_OUT: begin
        frame_valid         <= res_valid;
        frame_shown         <= res_shown;
        frames_dropped      <= res_dropped;
        audio_bytes_written <= res_written;
        audio_started       <= sink_running;
        audio_unavailable   <= audio_disabled;
      end
      default: ;
    endcase
  end

  `AVS_ASSERT_IMP(a_count_range, 1'b1, count <= CNT_W'(QUEUE_DEPTH), "queue count over depth")
  `AVS_ASSERT_IMP(a_sink_state, 1'b1, !(sink_running && audio_disabled), "sink running while disabled")
  `AVS_ASSERT_NXT(a_show_pop, cmd.op == avs_pkg::OP_SHOW, count == $past(count) - 1'b1, "show did not pop")
  `AVS_ASSERT_IMP(a_div_start, div_start, !div_busy, "divider restarted while busy")
endmodule

@@ design/avs_ctrl.sv @@
// controller: sequences each event through the datapath, owns handshakes
// depends on avs_pkg
module avs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              ev_valid,
  input  logic [1:0]        ev_mode,
  output logic              ev_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  avs_pkg::status_t  status,
  output avs_pkg::cmd_t     cmd
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_VIDEO  = 4'd1;
  localparam logic [3:0] S_AUDIO  = 4'd2;
  localparam logic [3:0] S_WRITE  = 4'd3;
  localparam logic [3:0] S_CHECK  = 4'd4;
  localparam logic [3:0] S_ABASE  = 4'd5;
  localparam logic [3:0] S_ADIV   = 4'd6;
  localparam logic [3:0] S_SETUP  = 4'd7;
  localparam logic [3:0] S_VSTART = 4'd8;
  localparam logic [3:0] S_VDIV   = 4'd9;
  localparam logic [3:0] S_DIFF   = 4'd10;
  localparam logic [3:0] S_DECIDE = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  logic [3:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd.op     = avs_pkg::OP_NONE;
    ev_ready   = state == S_IDLE;
    unique case (state)
      S_IDLE: if (ev_valid) begin
        cmd.op = avs_pkg::OP_LOAD;
        unique case (ev_mode)
          avs_pkg::MODE_VIDEO: state_next = S_VIDEO;
          avs_pkg::MODE_AUDIO: state_next = S_AUDIO;
          avs_pkg::MODE_TICK:  state_next = S_WRITE;
          default:             state_next = S_DONE;
        endcase
      end
      S_VIDEO: begin
        cmd.op     = avs_pkg::OP_VIDEO;
        state_next = S_DONE;
      end
      S_AUDIO: begin
        cmd.op     = avs_pkg::OP_AUDIO;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.op     = avs_pkg::OP_WRITE;
        state_next = (status.mode == avs_pkg::MODE_TICK) ? S_CHECK : S_DONE;
      end
      S_CHECK: state_next = status.go ? S_ABASE : S_DONE;
      S_ABASE: begin
        cmd.op     = avs_pkg::OP_ABASE;
        state_next = S_ADIV;
      end
      S_ADIV: if (!status.div_busy) state_next = S_SETUP;
      S_SETUP: begin
        cmd.op     = avs_pkg::OP_SETUP;
        state_next = S_VSTART;
      end
      S_VSTART: begin
        if (status.q_empty) state_next = S_DONE;
        else begin
          cmd.op     = avs_pkg::OP_VSTART;
          state_next = S_VDIV;
        end
      end
      S_VDIV: if (!status.div_busy) state_next = S_DIFF;
      S_DIFF: begin
        cmd.op     = avs_pkg::OP_DIFF;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (status.wait_f) state_next = S_DONE;
        else if (status.drop_f) begin
          cmd.op     = avs_pkg::OP_DROP;
          state_next = S_VSTART;
        end else begin
          cmd.op     = avs_pkg::OP_SHOW;
          state_next = S_DONE;
        end
      end
      S_DONE: if (!out_valid || out_ready) begin
        cmd.op     = avs_pkg::OP_OUT;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == avs_pkg::OP_OUT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end
endmodule

@@ design/av_sync_video_frame_scheduler_top.sv @@
// av sync video frame scheduler: audio-master-clock pacing of decoded frames
// event channel ev (video frame, audio chunk, tick or unused code), result channel res and
// a config write port (cfg_we, cfg_index, cfg_data); each event gives one result transaction
// a video event queues its frame; an audio event adds its bytes and writes to the device;
// a tick writes and then, when playback may go, examines queued frames in order, dropping
// late ones, until one is shown, one is early or the queue empties; the tick cost is set
// by the rtp to microsecond conversion, run for the audio base and every examined frame
// (reciprocal multiply, remainder step, scale step)
// one event is in work at a time and ev.ready is high only while the controller idles, so
// a further event waits at the input until the controller is back in idle
// the result sits in an output register and the next event is accepted while it waits;
// while res.ready stays low that event finishes and holds until the register frees,
// and no further event is accepted before then; reset (rst, synchronous) empties the
// frame queue, clears audio state and flags, drops res.valid and restores register
// defaults; no clearing pass is needed; config writes take effect at the next edge; the
// user must issue them only while no event is in work, as the block does not enforce it
module av_sync_video_frame_scheduler_top #(
  parameter int QUEUE_DEPTH = avs_pkg::QUEUE_DEPTH_DEF,
  parameter int TIME_WIDTH  = avs_pkg::TIME_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [avs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [avs_pkg::CFG_DAT_W-1:0] cfg_data,
  avs_ev_if.sink                        ev,
  avs_res_if.source                     res
);
  avs_pkg::cmd_t    cmd;
  avs_pkg::status_t status;

  avs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .ev_valid (ev.valid),
    .ev_mode  (ev.mode),
    .ev_ready (ev.ready),
    .out_valid(res.valid),
    .out_ready(res.ready),
    .status   (status),
    .cmd      (cmd)
  );

  avs_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mode               (ev.mode),
    .rtp_timestamp      (ev.rtp_timestamp),
    .frame_handle       (ev.frame_handle),
    .audio_byte_count   (ev.audio_byte_count),
    .now_us             (ev.now_us),
    .audio_played_us    (ev.audio_played_us),
    .sink_idle          (ev.sink_idle),
    .device_free_bytes  (ev.device_free_bytes),
    .device_ok          (ev.device_ok),
    .cmd                (cmd),
    .status             (status),
    .frame_valid        (res.frame_valid),
    .frame_shown        (res.frame_shown),
    .frames_dropped     (res.frames_dropped),
    .audio_bytes_written(res.audio_bytes_written),
    .audio_started      (res.audio_started),
    .audio_unavailable  (res.audio_unavailable)
  );
endmodule
